// ===== design/fmvc_pkg.sv =====
// Shared types, constants and codes of the fused multiply valid convolution block.
package fmvc_pkg;

	localparam int MAX_IMAGE_SIDE  = 1024;
	localparam int MAX_KERNEL_SIDE = 7;
	localparam int SAMPLE_BITS     = 16;

	localparam int COL_W      = $clog2(MAX_IMAGE_SIDE);
	localparam int SIDE_W     = COL_W + 1;
	localparam int K_W        = $clog2(MAX_KERNEL_SIDE + 1);
	localparam int CELLS      = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
	localparam int CHAIN_W    = $clog2(CELLS);
	localparam int LINE_ROWS  = MAX_KERNEL_SIDE - 1;
	localparam int SLOT_W     = $clog2(LINE_ROWS);
	localparam int LINE_DEPTH = (1 << SLOT_W) * MAX_IMAGE_SIDE;
	localparam int LINE_AW    = SLOT_W + COL_W;
	localparam int PROD_W     = 2 * SAMPLE_BITS;
	localparam int SUM_W      = 40;
	localparam int FRAC_SHIFT = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SIDE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FUSED       = 2'd2;

	localparam logic CMD_COEF  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	typedef struct packed {
		logic                          cmd;
		logic signed [SAMPLE_BITS-1:0] sample_a;
		logic signed [SAMPLE_BITS-1:0] sample_b;
		logic signed [SAMPLE_BITS-1:0] coefficient;
	} in_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] conv_sum;
		logic [COL_W-1:0]        out_row;
		logic [COL_W-1:0]        out_col;
		logic                    last_of_frame;
	} out_word_t;

	typedef struct packed {
		logic                          win_shift;
		logic                          win_load;
		logic signed [SAMPLE_BITS-1:0] win_data;
		logic                          coef_we;
		logic signed [SAMPLE_BITS-1:0] coef_data;
		logic                          snap;
		logic                          in_kernel;
		logic                          chain_shift;
		logic                          coef_shift;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIXEL,
		ST_READ,
		ST_WRITE,
		ST_SNAP,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== design/fmvc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module fmvc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/fmvc_cell.sv =====
// One window cell: a window pixel, its kernel coefficient and one stage of the MAC chain.
module fmvc_cell (
	input  logic                                  clk,
	input  fmvc_pkg::cell_ctrl_t                  ctrl,
	input  logic signed [fmvc_pkg::SAMPLE_BITS-1:0] right_win,
	input  logic signed [fmvc_pkg::SAMPLE_BITS-1:0] next_pix,
	input  logic signed [fmvc_pkg::SAMPLE_BITS-1:0] next_coef,
	output logic signed [fmvc_pkg::SAMPLE_BITS-1:0] win,
	output logic signed [fmvc_pkg::SAMPLE_BITS-1:0] chain_pix,
	output logic signed [fmvc_pkg::SAMPLE_BITS-1:0] chain_coef
);
	import fmvc_pkg::*;

	logic signed [SAMPLE_BITS-1:0] win_q;
	logic signed [SAMPLE_BITS-1:0] coef_q;
	logic signed [SAMPLE_BITS-1:0] chain_pix_q;
	logic signed [SAMPLE_BITS-1:0] chain_coef_q;

	always_ff @(posedge clk) begin
		if (ctrl.win_load) begin
			win_q <= ctrl.win_data;
		end else if (ctrl.win_shift) begin
			win_q <= right_win;
		end
		if (ctrl.coef_we) begin
			coef_q <= ctrl.coef_data;
		end
		// Window cells outside the active kernel enter the chain as zero.
		if (ctrl.snap) begin
			chain_pix_q <= ctrl.in_kernel ? win_q : '0;
		end else if (ctrl.chain_shift) begin
			chain_pix_q <= next_pix;
		end
		// Coefficients sit in raster order of the loaded kernel and advance
		// only past window cells that belong to the kernel.
		if (ctrl.snap) begin
			chain_coef_q <= coef_q;
		end else if (ctrl.coef_shift) begin
			chain_coef_q <= next_coef;
		end
	end

	assign win        = win_q;
	assign chain_pix  = chain_pix_q;
	assign chain_coef = chain_coef_q;

endmodule

// ===== design/fused_mul_valid_conv2d_top.sv =====
// Top level of the streaming valid-only 2D convolution with optional fused multiply.
//
// Words with cmd 0 load kernel coefficients in raster order; words with cmd 1
// carry pixels in raster order. In fused mode a pixel is sample_a*sample_b
// shifted right by 8 (toward minus infinity) and saturated to 16 bits;
// otherwise it is sample_a. Line memory keeps the last kernel_side-1 rows and
// a 7x7 grid of cells holds the window and the kernel coefficients, the
// latter in the raster order in which they were loaded. Once a full window is
// present one result word carries the exact Q24.16 sum with its row and
// column. A coefficient word leaves the block idle and ready for the next
// word. A pixel word stalls the input until it is through: the word is
// taken, the pixel is formed, the kernel_side-1 stored rows are read from
// the line memory through its single read port, the pixel is written, and
// for a result the window is snapped, all 49 cells walk past a single
// multiplier, the last product drains and the sum is handed to the output
// register once that register is free. The next word is accepted while a
// finished result still waits in the output register. Configuration writes
// are always ready and must only be issued while the block is idle; writing
// image_side or kernel_side restarts the frame and the coefficient count.
module fused_mul_valid_conv2d_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  fmvc_pkg::in_word_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fmvc_pkg::out_word_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fmvc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fmvc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fmvc_pkg::*;

	state_t state_q, state_d;

	// Configuration registers.
	logic [SIDE_W-1:0] image_side_q;
	logic [K_W-1:0]    kernel_side_q;
	logic              fused_q;
	logic [SIDE_W-1:0] n_eff;
	logic [K_W-1:0]    k_eff;
	logic [CHAIN_W-1:0] kk_w;

	// Position and coefficient counters.
	logic [COL_W-1:0]   row_q, col_q;
	logic [SLOT_W-1:0]  row_slot_q;
	logic [CHAIN_W-1:0] coef_idx_q;

	in_word_t                      in_q;
	logic signed [SAMPLE_BITS-1:0] px_q;
	logic signed [PROD_W-1:0]      mul_w;
	logic signed [PROD_W-1:0]      shifted_w;
	logic signed [SAMPLE_BITS-1:0] px_d;

	logic [K_W-1:0]    rd_r_q, rd_r_s1;
	logic [SLOT_W-1:0] rd_slot_q;
	logic              rd_v_s1;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	logic [CHAIN_W-1:0]       mac_cnt_q;
	logic [K_W-1:0]           mac_r_q, mac_c_q;
	logic                     mac_in_kernel_w;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_v_s1;
	logic signed [SUM_W-1:0]  acc_q;

	logic [COL_W-1:0] res_row_q, res_col_q;
	logic             res_last_q;

	logic      out_valid_q;
	out_word_t out_word_q;

	// The grid of cells, index r*7+c; the chain runs toward cell 0.
	logic signed [SAMPLE_BITS-1:0] cell_win  [CELLS];
	logic signed [SAMPLE_BITS-1:0] cell_pix  [CELLS];
	logic signed [SAMPLE_BITS-1:0] cell_coef [CELLS];

	logic in_acc, cfg_acc, coef_acc, pixel_acc;
	logic emit_w, col_last_w, row_last_w, out_load_w;

	// Decoded control from the state machine.
	logic do_shift, do_read, do_write, do_snap, do_mac;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign coef_acc  = in_acc && (in_data.cmd == CMD_COEF);
	assign pixel_acc = in_acc && (in_data.cmd == CMD_PIXEL);

	// Effective sides: zero counts as one, image side clamps, even kernel side rounds down.
	always_comb begin
		n_eff = image_side_q;
		if (n_eff == '0) begin
			n_eff = SIDE_W'(1);
		end else if (n_eff > SIDE_W'(MAX_IMAGE_SIDE)) begin
			n_eff = SIDE_W'(MAX_IMAGE_SIDE);
		end
		k_eff = kernel_side_q;
		if (k_eff == '0) begin
			k_eff = K_W'(1);
		end else if (k_eff > K_W'(MAX_KERNEL_SIDE)) begin
			k_eff = K_W'(MAX_KERNEL_SIDE);
		end
		if (!k_eff[0]) begin
			k_eff = k_eff - K_W'(1);
		end
	end

	// Number of coefficients in the active kernel.
	assign kk_w = CHAIN_W'(k_eff) * CHAIN_W'(k_eff);

	assign emit_w     = ({1'b0, row_q} + SIDE_W'(1) >= SIDE_W'(k_eff)) &&
	                    ({1'b0, col_q} + SIDE_W'(1) >= SIDE_W'(k_eff));
	assign col_last_w = ({1'b0, col_q} + SIDE_W'(1) >= n_eff);
	assign row_last_w = ({1'b0, row_q} + SIDE_W'(1) >= n_eff);
	assign out_load_w = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign mac_in_kernel_w = (mac_r_q < k_eff) && (mac_c_q < k_eff);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pixel_acc) state_d = ST_PIXEL;
			end
			ST_PIXEL: begin
				state_d = (k_eff == K_W'(1)) ? ST_WRITE : ST_READ;
			end
			ST_READ: begin
				if (rd_r_q == k_eff - K_W'(2)) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = emit_w ? ST_SNAP : ST_IDLE;
			end
			ST_SNAP: begin
				state_d = ST_MAC;
			end
			ST_MAC: begin
				if (mac_cnt_q == CHAIN_W'(CELLS - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load_w) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		do_shift = 1'b0;
		do_read  = 1'b0;
		do_write = 1'b0;
		do_snap  = 1'b0;
		do_mac   = 1'b0;
		unique case (state_q)
			ST_PIXEL: do_shift = 1'b1;
			ST_READ:  do_read  = 1'b1;
			ST_WRITE: do_write = 1'b1;
			ST_SNAP:  do_snap  = 1'b1;
			ST_MAC:   do_mac   = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_side_q  <= SIDE_W'(MAX_IMAGE_SIDE);
			kernel_side_q <= K_W'(3);
			fused_q       <= 1'b0;
			row_q         <= '0;
			col_q         <= '0;
			row_slot_q    <= '0;
			coef_idx_q    <= '0;
		end else begin
			if (cfg_acc && (cfg_index == CFG_IMAGE_SIDE || cfg_index == CFG_KERNEL_SIDE)) begin
				if (cfg_index == CFG_IMAGE_SIDE) begin
					image_side_q <= cfg_data;
				end else begin
					kernel_side_q <= cfg_data[K_W-1:0];
				end
				row_q      <= '0;
				col_q      <= '0;
				row_slot_q <= '0;
				coef_idx_q <= '0;
			end else begin
				if (cfg_acc && cfg_index == CFG_FUSED) begin
					fused_q <= cfg_data[0];
				end
				if (coef_acc) begin
					coef_idx_q <= (coef_idx_q + CHAIN_W'(1) >= kk_w) ? '0 :
					              coef_idx_q + CHAIN_W'(1);
				end
				if (do_write) begin
					if (col_last_w) begin
						col_q <= '0;
						if (row_last_w) begin
							row_q      <= '0;
							row_slot_q <= '0;
						end else begin
							row_q <= row_q + COL_W'(1);
							// The slot of a row is its index modulo kernel_side-1.
							if (k_eff == K_W'(1) ||
							    K_W'(row_slot_q) + K_W'(1) >= k_eff - K_W'(1)) begin
								row_slot_q <= '0;
							end else begin
								row_slot_q <= row_slot_q + SLOT_W'(1);
							end
						end
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// Pixel forming: floor shift of the product, then saturation to the sample width.
	assign mul_w     = PROD_W'(in_q.sample_a) * PROD_W'(in_q.sample_b);
	assign shifted_w = mul_w >>> FRAC_SHIFT;
	always_comb begin
		if (!fused_q) begin
			px_d = in_q.sample_a;
		end else if (shifted_w > PROD_W'((1 << (SAMPLE_BITS - 1)) - 1)) begin
			px_d = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		end else if (shifted_w < -PROD_W'(1 << (SAMPLE_BITS - 1))) begin
			px_d = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		end else begin
			px_d = shifted_w[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_data;
		end
		if (do_shift) begin
			px_q      <= px_d;
			rd_r_q    <= '0;
			rd_slot_q <= row_slot_q;
		end else if (do_read) begin
			rd_r_q    <= rd_r_q + K_W'(1);
			rd_slot_q <= (K_W'(rd_slot_q) == k_eff - K_W'(2)) ? '0 : rd_slot_q + SLOT_W'(1);
		end
		rd_r_s1 <= rd_r_q;
		if (do_write) begin
			res_row_q  <= row_q - COL_W'(k_eff - K_W'(1));
			res_col_q  <= col_q - COL_W'(k_eff - K_W'(1));
			res_last_q <= row_last_w && col_last_w;
		end
		prod_s1 <= PROD_W'(cell_pix[0]) * PROD_W'(cell_coef[0]);
		if (do_snap) begin
			acc_q <= '0;
		end else if (prod_v_s1) begin
			acc_q <= acc_q + SUM_W'(prod_s1);
		end
		if (out_load_w) begin
			out_word_q.conv_sum      <= acc_q;
			out_word_q.out_row       <= res_row_q;
			out_word_q.out_col       <= res_col_q;
			out_word_q.last_of_frame <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1     <= 1'b0;
			prod_v_s1   <= 1'b0;
			mac_cnt_q   <= '0;
			mac_r_q     <= '0;
			mac_c_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1   <= do_read;
			// Only window cells inside the kernel add to the sum.
			prod_v_s1 <= do_mac && mac_in_kernel_w;
			mac_cnt_q <= do_mac ? mac_cnt_q + CHAIN_W'(1) : '0;
			if (!do_mac) begin
				mac_r_q <= '0;
				mac_c_q <= '0;
			end else if (mac_c_q == K_W'(MAX_KERNEL_SIDE - 1)) begin
				mac_c_q <= '0;
				mac_r_q <= mac_r_q + K_W'(1);
			end else begin
				mac_c_q <= mac_c_q + K_W'(1);
			end
			if (out_load_w) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Line memory: kernel_side-1 rows addressed by slot and column.
	fmvc_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (do_write && (k_eff != K_W'(1))),
		.waddr({row_slot_q, col_q}),
		.wdata(px_q),
		.re   (do_read),
		.raddr({rd_slot_q, col_q}),
		.rdata(ram_rdata)
	);

	for (genvar r = 0; r < MAX_KERNEL_SIDE; r++) begin : g_row
		for (genvar c = 0; c < MAX_KERNEL_SIDE; c++) begin : g_col
			localparam int IDX = r * MAX_KERNEL_SIDE + c;
			cell_ctrl_t                    ctrl;
			logic signed [SAMPLE_BITS-1:0] right_w, next_pix_w, next_coef_w;
			logic                          last_row_w;

			assign last_row_w = (K_W'(r) == k_eff - K_W'(1));
			always_comb begin
				ctrl.win_shift   = do_shift;
				ctrl.win_load    = (K_W'(c) == k_eff - K_W'(1)) &&
				                   ((rd_v_s1 && rd_r_s1 == K_W'(r)) || (do_write && last_row_w));
				ctrl.win_data    = (do_write && last_row_w) ? px_q : ram_rdata;
				ctrl.coef_we     = coef_acc && (coef_idx_q == CHAIN_W'(IDX));
				ctrl.coef_data   = in_data.coefficient;
				ctrl.snap        = do_snap;
				ctrl.in_kernel   = (K_W'(r) < k_eff) && (K_W'(c) < k_eff);
				ctrl.chain_shift = do_mac;
				ctrl.coef_shift  = do_mac && mac_in_kernel_w;
			end
			if (c < MAX_KERNEL_SIDE - 1) begin : g_right
				assign right_w = cell_win[IDX + 1];
			end else begin : g_edge
				assign right_w = '0;
			end
			if (IDX < CELLS - 1) begin : g_next
				assign next_pix_w  = cell_pix[IDX + 1];
				assign next_coef_w = cell_coef[IDX + 1];
			end else begin : g_end
				assign next_pix_w  = '0;
				assign next_coef_w = '0;
			end

			fmvc_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.right_win (right_w),
				.next_pix  (next_pix_w),
				.next_coef (next_coef_w),
				.win       (cell_win[IDX]),
				.chain_pix (cell_pix[IDX]),
				.chain_coef(cell_coef[IDX])
			);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

endmodule

// ===== design/fmvc_checker.sv =====
// Port-level checker of the convolution top level and its bind statement.
module fmvc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input fmvc_pkg::in_word_t              in_data,
	input logic                            out_valid,
	input logic                            out_stall,
	input fmvc_pkg::out_word_t             out_data,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [fmvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [fmvc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fmvc_pkg::*;

	// A stalled result word stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// A pixel word keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd == CMD_PIXEL |=> in_stall)
		else $error("pixel word did not occupy the block");

	// A result never appears in the cycle after a word was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && !in_stall))
		else $error("result appeared too early");

	// The last result of a frame sits at equal row and column.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_of_frame |-> out_data.out_row == out_data.out_col)
		else $error("frame end off the diagonal");

endmodule

bind fused_mul_valid_conv2d_top fmvc_checker u_fmvc_checker (.*);

// ===== test/tb_fused_mul_valid_conv2d_top.sv =====
// Self-checking testbench for the streaming valid-only 2D convolution block.
`timescale 1ns / 1ps

module tb_fused_mul_valid_conv2d_top;
	import fmvc_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fused_mul_valid_conv2d_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Free-running 12 ns clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Shadow copy of the block's configuration and convolution state.
	int unsigned side_reg;
	int unsigned kside_reg;
	bit fused_reg;
	longint line_mem[LINE_ROWS][MAX_IMAGE_SIDE];
	longint window[MAX_KERNEL_SIDE][MAX_KERNEL_SIDE];
	longint kernel_coefs[CELLS];
	int unsigned cur_row;
	int unsigned cur_col;
	int unsigned coef_pos;

	// Result words still owed by the block, oldest first.
	out_word_t pending_sums[$];
	int error_count;
	bit word_taken;
	int hold_cycles;
	bit stall_quiet;

	function automatic int unsigned image_n();
		int unsigned n;
		n = side_reg;
		if (n < 1) n = 1;
		if (n > MAX_IMAGE_SIDE) n = MAX_IMAGE_SIDE;
		return n;
	endfunction

	function automatic int unsigned kernel_k();
		int unsigned k;
		k = kside_reg;
		if (k < 1) k = 1;
		if (k > MAX_KERNEL_SIDE) k = MAX_KERNEL_SIDE;
		if (k % 2 == 0) k = k - 1;
		return k;
	endfunction

	// Pixel formation: plain sample, or the Q8.8 product floored and clamped to 16 bits.
	function automatic longint form_pixel(logic signed [15:0] a, logic signed [15:0] b);
		longint p;
		if (!fused_reg) return longint'(a);
		p = longint'(a) * longint'(b);
		p = p >>> FRAC_SHIFT;
		if (p > 32767) p = 32767;
		if (p < -32768) p = -32768;
		return p;
	endfunction

	// Advance the shadow state by one accepted word and queue any result it causes.
	task automatic convolve_word(in_word_t w);
		int unsigned n, k, row, col, slot;
		longint px, acc;
		out_word_t res;
		n = image_n();
		k = kernel_k();
		if (w.cmd == CMD_COEF) begin
			if (coef_pos >= k * k) coef_pos = 0;
			kernel_coefs[coef_pos] = longint'(w.coefficient);
			coef_pos = (coef_pos + 1 >= k * k) ? 0 : coef_pos + 1;
			return;
		end
		row = cur_row;
		col = cur_col;
		if (row >= n || col >= n) begin
			row = 0;
			col = 0;
		end
		px = form_pixel(w.sample_a, w.sample_b);
		for (int r = 0; r < k; r++)
			for (int c = 0; c + 1 < k; c++)
				window[r][c] = window[r][c + 1];
		if (k > 1) begin
			for (int r = 0; r + 1 < k; r++) begin
				slot = (row + r) % (k - 1);
				window[r][k - 1] = line_mem[slot][col];
			end
			line_mem[row % (k - 1)][col] = px;
		end
		window[k - 1][k - 1] = px;
		if (row + 1 >= k && col + 1 >= k) begin
			acc = 0;
			for (int r = 0; r < k; r++)
				for (int c = 0; c < k; c++)
					acc += window[r][c] * kernel_coefs[r * k + c];
			res.conv_sum = acc[SUM_W-1:0];
			res.out_row = COL_W'(row - (k - 1));
			res.out_col = COL_W'(col - (k - 1));
			res.last_of_frame = (row - (k - 1) == n - k) && (col - (k - 1) == n - k);
			pending_sums.push_back(res);
		end
		col++;
		if (col >= n) begin
			col = 0;
			row++;
			if (row >= n) row = 0;
		end
		cur_row = row;
		cur_col = col;
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one word and hold it until the block takes it. The shadow model
	// is updated at the edge of acceptance.
	task automatic send_word(in_word_t w, bit allow_gap = 1);
		int gap;
		gap = allow_gap ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		convolve_word(w);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Let every owed result drain, then give a word that yields nothing time to finish.
	task automatic wait_idle();
		release_input();
		wait (pending_sums.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_IMAGE_SIDE: side_reg = value & 32'h7FF;
			CFG_KERNEL_SIDE: kside_reg = value & 32'h7;
			CFG_FUSED: fused_reg = value[0];
			default: ;
		endcase
		if (idx == CFG_IMAGE_SIDE || idx == CFG_KERNEL_SIDE) begin
			cur_row = 0;
			cur_col = 0;
			coef_pos = 0;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(int unsigned n, int unsigned k, bit fused);
		write_reg(CFG_IMAGE_SIDE, n);
		write_reg(CFG_KERNEL_SIDE, k);
		write_reg(CFG_FUSED, fused);
	endtask

	task automatic send_coef(logic signed [15:0] value);
		in_word_t w;
		w = '0;
		w.cmd = CMD_COEF;
		w.coefficient = value;
		w.sample_a = $urandom();
		w.sample_b = $urandom();
		send_word(w);
	endtask

	task automatic send_pixel(logic signed [15:0] a, logic signed [15:0] b, bit allow_gap = 1);
		in_word_t w;
		w.cmd = CMD_PIXEL;
		w.sample_a = a;
		w.sample_b = b;
		w.coefficient = $urandom();
		send_word(w, allow_gap);
	endtask

	// Loads a complete random kernel for the current kernel side.
	task automatic load_random_kernel();
		int unsigned k;
		k = kernel_k();
		for (int i = 0; i < k * k; i++) send_coef($urandom());
	endtask

	// Extremes of every field, both pixel modes, a coefficient wrap and a full frame.
	task automatic test_directed();
		logic signed [15:0] edge_vals[5];
		edge_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0100};
		setup(4, 3, 0);
		// Ten coefficients: the last one wraps and overwrites the first.
		for (int i = 0; i < 10; i++) send_coef(edge_vals[i % 5]);
		for (int i = 0; i < 16; i++) send_pixel(edge_vals[i % 5], 16'sh0000);
		write_reg(CFG_FUSED, 1);
		// Positive and negative saturation, a floored negative product, then positive saturation again.
		send_pixel(16'sh8000, 16'sh8000);
		send_pixel(16'sh7FFF, 16'sh8000);
		send_pixel(16'shFFFF, 16'sh0001);
		send_pixel(16'sh7FFF, 16'sh7FFF);
		for (int i = 0; i < 12; i++) send_pixel($urandom(), $urandom());
	endtask

	// Clamped and rounded register values, including a kernel wider than the image.
	task automatic test_register_edges();
		// Image side 0 counts as 1; with a 1x1 kernel every pixel ends a frame.
		setup(0, 0, 0);
		send_coef(16'sh0180);
		for (int i = 0; i < 4; i++) send_pixel($urandom(), $urandom());
		// Kernel side 7 on a 5-pixel image never produces a result.
		setup(5, 7, 1);
		load_random_kernel();
		for (int i = 0; i < 30; i++) send_pixel($urandom(), $urandom());
		// An even kernel side rounds down to the next odd one.
		setup(6, 4, 0);
		load_random_kernel();
		for (int i = 0; i < 36; i++) send_pixel($urandom(), $urandom());
		// Side 2047 clamps to the largest image; only part of the first row is streamed.
		setup(2047, 1, 0);
		send_coef($urandom());
		for (int i = 0; i < 20; i++) send_pixel($urandom(), $urandom());
		setup(MAX_IMAGE_SIDE, MAX_KERNEL_SIDE, 0);
		load_random_kernel();
		for (int i = 0; i < 10; i++) send_pixel($urandom(), $urandom());
		// An index past the register list is ignored and the frame carries on.
		setup(3, 1, 0);
		send_coef(16'sh0200);
		for (int i = 0; i < 4; i++) send_pixel($urandom(), $urandom());
		write_reg(2'd3, $urandom());
		for (int i = 0; i < 5; i++) send_pixel($urandom(), $urandom());
	endtask

	// The receiver holds off for a long stretch while pixels keep coming.
	task automatic test_backpressure();
		setup(8, 1, 1);
		send_coef($urandom());
		hold_cycles = 1500;
		for (int i = 0; i < 24; i++) send_pixel($urandom(), $urandom(), 0);
	endtask

	// Random phases: mostly a full kernel load and whole frames of random pixels,
	// sometimes a stray coefficient in the middle of the stream.
	task automatic test_random(int unsigned budget);
		int unsigned sent, n, k, frame;
		sent = 0;
		while (sent < budget) begin
			k = $urandom_range(0, 7);
			if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 4);
			else n = $urandom_range(7, 12);
			setup(n, k, $urandom_range(0, 1));
			load_random_kernel();
			sent += kernel_k() * kernel_k();
			frame = image_n() * image_n() * $urandom_range(1, 2) + $urandom_range(0, 5);
			for (int i = 0; i < frame; i++) begin
				if ($urandom_range(0, 49) == 0) send_coef($urandom());
				else send_pixel($urandom(), $urandom());
				sent++;
			end
		end
	endtask

	// Result checker: each accepted word is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected result word row=%0d col=%0d", out_data.out_row, out_data.out_col);
				error_count++;
			end else begin
				out_word_t want;
				want = pending_sums.pop_front();
				if (out_data.conv_sum !== want.conv_sum) begin
					$error("conv_sum expected %0d got %0d", want.conv_sum, out_data.conv_sum);
					error_count++;
				end
				if (out_data.out_row !== want.out_row) begin
					$error("out_row expected %0d got %0d", want.out_row, out_data.out_row);
					error_count++;
				end
				if (out_data.out_col !== want.out_col) begin
					$error("out_col expected %0d got %0d", want.out_col, out_data.out_col);
					error_count++;
				end
				if (out_data.last_of_frame !== want.last_of_frame) begin
					$error("last_of_frame expected %0d got %0d",
						want.last_of_frame, out_data.last_of_frame);
					error_count++;
				end
			end
		end
	end

	// Receiver stall pattern. A requested hold-off is counted down here; otherwise
	// the stall alternates between quiet stretches and random bursts.
	initial begin
		int left;
		left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (left > 0) begin
				left--;
				out_stall <= stall_quiet ? 1'b0 : ($urandom_range(0, 99) < 30);
			end else begin
				stall_quiet = ($urandom_range(0, 3) == 0);
				left = $urandom_range(20, 120);
				if (!stall_quiet && $urandom_range(0, 19) == 0) begin
					// Occasional long stall.
					out_stall <= 1'b1;
					hold_cycles = $urandom_range(20, 60);
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Watchdog: ends the run if nothing is accepted on any channel for too long.
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("tb_fused_mul_valid_conv2d_top: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IMAGE_SIDE;
		cfg_data = '0;
		error_count = 0;
		hold_cycles = 0;
		stall_quiet = 1'b0;
		side_reg = MAX_IMAGE_SIDE;
		kside_reg = 3;
		fused_reg = 1'b0;
		cur_row = 0;
		cur_col = 0;
		coef_pos = 0;
		for (int s = 0; s < LINE_ROWS; s++)
			for (int c = 0; c < MAX_IMAGE_SIDE; c++) line_mem[s][c] = 0;
		for (int r = 0; r < MAX_KERNEL_SIDE; r++)
			for (int c = 0; c < MAX_KERNEL_SIDE; c++) window[r][c] = 0;
		for (int i = 0; i < CELLS; i++) kernel_coefs[i] = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_edges();
		test_backpressure();
		test_random(800);

		wait_idle();
		if (error_count == 0)
			$display("tb_fused_mul_valid_conv2d_top: clean");
		else
			$display("tb_fused_mul_valid_conv2d_top: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/fmvc_pkg.sv
design/fmvc_ram.sv
design/fmvc_cell.sv
design/fused_mul_valid_conv2d_top.sv
design/fmvc_checker.sv
test/tb_fused_mul_valid_conv2d_top.sv
